@@ src/vrp_pkg.sv @@
`timescale 1ns / 1ps

package vrp_pkg;

  // Access kinds
  localparam logic [1:0] ACT_READ   = 2'd0;
  localparam logic [1:0] ACT_WRITE  = 2'd1;
  localparam logic [1:0] ACT_STATUS = 2'd2;

  // Register numbers, offset from the register base
  localparam logic [2:0] REG_CTRL     = 3'd0;
  localparam logic [2:0] REG_MASK     = 3'd1;
  localparam logic [2:0] REG_STATUS   = 3'd2;
  localparam logic [2:0] REG_OAM_ADDR = 3'd3;
  localparam logic [2:0] REG_OAM_DATA = 3'd4;
  localparam logic [2:0] REG_SCROLL   = 3'd5;
  localparam logic [2:0] REG_ADDR     = 3'd6;
  localparam logic [2:0] REG_DATA     = 3'd7;

  localparam int unsigned SPRITE_BYTES    = 256;
  localparam int unsigned NAMETABLE_BYTES = 1024;
  localparam int unsigned PATTERN_BYTES   = 8192;
  localparam int unsigned PALETTE_BYTES   = 32;
  localparam int unsigned NT_SPAN         = 4 * NAMETABLE_BYTES;
  localparam int unsigned NT_AW           = $clog2(NT_SPAN);
  localparam int unsigned PAL_AW          = $clog2(PALETTE_BYTES);

  // Packed video memory: pattern, then name tables, then palette
  localparam int unsigned VRAM_NT_BASE  = PATTERN_BYTES;
  localparam int unsigned VRAM_PAL_BASE = PATTERN_BYTES + NT_SPAN;
  localparam int unsigned VRAM_DEPTH    = VRAM_PAL_BASE + PALETTE_BYTES;
  localparam int unsigned VRAM_AW       = $clog2(VRAM_DEPTH);

  // Bus address map of video memory
  localparam logic [15:0] BUS_NT_LO  = 16'h2000;
  localparam logic [15:0] BUS_NT_HI  = 16'h3000;
  localparam logic [15:0] BUS_PAL_LO = 16'h3F00;
  localparam logic [15:0] BUS_PAL_HI = 16'h3F20;

  localparam logic [15:0] STEP_NARROW = 16'd1;
  localparam logic [15:0] STEP_WIDE   = 16'd32;

  localparam logic [7:0] STATUS_KEEP = 8'h7F;

  typedef struct packed {
    logic               hit;
    logic [VRAM_AW-1:0] idx;
  } vmap_t;

  // Map a bus address onto the packed video memory
  function automatic vmap_t vram_map(input logic [15:0] a);
    vmap_t m;
    m.hit = 1'b0;
    m.idx = '0;
    if (a < BUS_NT_LO) begin
      m.hit = 1'b1;
      m.idx = VRAM_AW'(a);
    end else if (a < BUS_NT_HI) begin
      m.hit = 1'b1;
      m.idx = VRAM_AW'(VRAM_NT_BASE) + VRAM_AW'(a[NT_AW-1:0]);
    end else if (a >= BUS_PAL_LO && a < BUS_PAL_HI) begin
      m.hit = 1'b1;
      m.idx = VRAM_AW'(VRAM_PAL_BASE) + VRAM_AW'(a[PAL_AW-1:0]);
    end
    return m;
  endfunction

endpackage

@@ src/vrp_req_if.sv @@
`timescale 1ns / 1ps

interface vrp_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [2:0] reg_index;
  logic [7:0] write_data;

  modport source (output valid, action, reg_index, write_data, input ready);
  modport sink   (input valid, action, reg_index, write_data, output ready);
endinterface

@@ src/vrp_rsp_if.sv @@
`timescale 1ns / 1ps

interface vrp_rsp_if;
  logic        valid;
  logic        ready;
  logic [7:0]  read_data;
  logic [7:0]  horizontal_scroll;
  logic [7:0]  vertical_scroll;
  logic [15:0] vram_pointer;

  modport source (output valid, read_data, horizontal_scroll, vertical_scroll, vram_pointer,
                  input ready);
  modport sink   (input valid, read_data, horizontal_scroll, vertical_scroll, vram_pointer,
                  output ready);
endinterface

@@ src/vrp_ram.sv @@
`timescale 1ns / 1ps

module vrp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = vrp_pkg::SPRITE_BYTES
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/video_register_port_with_vram.sv @@
`timescale 1ns / 1ps

// CPU-side register port of a video chip, with sprite RAM and video memory
// (pattern, four name tables, palette) held on chip. Each request beat is a
// register read, a register write or a status load from the renderer, and
// gives exactly one response beat carrying the read byte, both scroll values
// and the video memory pointer after the access. After reset the block sweeps
// both memories to zero, one entry a cycle, over all VRAM_DEPTH (12320) entries,
// and takes no request beat until the sweep is done. After that the accept
// cycle of an access reads sprite RAM and video memory at the current
// addresses, and the read state then uses the registered read data, writes
// memory back where needed, updates the register state and loads the response
// register once that register is free. A new request is taken only after the
// read state is left, so an access must finish before the next is accepted;
// the registered read of the memories is why the read state is needed. A held
// response beat stalls the read state but does not block the request side from being idle-ready.
module video_register_port_with_vram #(
  parameter int unsigned SPRITE_BYTES = vrp_pkg::SPRITE_BYTES
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  vrp_req_if.sink    req_i,
  vrp_rsp_if.source  rsp_o
);

  localparam int unsigned SprAw  = $clog2(SPRITE_BYTES);
  localparam int unsigned VramAw = vrp_pkg::VRAM_AW;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_READ  = 2'd2;

  logic [1:0] state_q, state_d;
  logic [VramAw-1:0] clr_cnt_q;

  // Architectural register state
  logic [7:0]  ctrl_q, ctrl_d;
  logic [7:0]  mask_q, mask_d;
  logic [7:0]  status_q, status_d;
  logic [7:0]  oam_addr_q, oam_addr_d;
  logic        toggle_q, toggle_d;
  logic [15:0] vaddr_q, vaddr_d;
  logic [7:0]  rbuf_q, rbuf_d;
  logic [7:0]  hscroll_q, hscroll_d;
  logic [7:0]  vscroll_q, vscroll_d;

  // Beat held across the memory read
  logic [1:0]        act_q;
  logic [2:0]        idx_q;
  logic [7:0]        wdata_q;
  logic [VramAw-1:0] vidx_q;
  logic              hit_q;

  // Response register
  logic        out_valid_q;
  logic [7:0]  out_rd_q;
  logic [7:0]  out_hs_q;
  logic [7:0]  out_vs_q;
  logic [15:0] out_ptr_q;

  logic              accept;
  logic              clearing;
  logic              out_free;
  logic              finish;
  vrp_pkg::vmap_t    vmap;
  logic [7:0]        rd;
  logic [7:0]        vmem_val;
  logic [15:0]       step;
  logic              vram_wr;
  logic              spr_wr;

  logic              vram_we;
  logic [VramAw-1:0] vram_waddr;
  logic [7:0]        vram_wdata;
  logic [7:0]        vram_rdata;
  logic              spr_we;
  logic [SprAw-1:0]  spr_waddr;
  logic [7:0]        spr_wdata;
  logic [7:0]        spr_rdata;

  assign clearing    = (state_q == ST_CLEAR);
  assign req_i.ready = (state_q == ST_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign out_free    = !out_valid_q || rsp_o.ready;
  assign finish      = (state_q == ST_READ) && out_free;
  assign vmap        = vrp_pkg::vram_map(vaddr_q);

  // Memories: the sweep owns the write ports until it ends
  assign vram_we    = clearing || (finish && vram_wr);
  assign vram_waddr = clearing ? clr_cnt_q : vidx_q;
  assign vram_wdata = clearing ? 8'h00 : wdata_q;

  assign spr_we    = clearing ? (clr_cnt_q < VramAw'(SPRITE_BYTES)) : (finish && spr_wr);
  assign spr_waddr = clearing ? clr_cnt_q[SprAw-1:0] : oam_addr_q[SprAw-1:0];
  assign spr_wdata = clearing ? 8'h00 : wdata_q;

  vrp_ram #(
    .WIDTH (8),
    .DEPTH (vrp_pkg::VRAM_DEPTH)
  ) u_vram (
    .clk_i   (clk_i),
    .we_i    (vram_we),
    .waddr_i (vram_waddr),
    .wdata_i (vram_wdata),
    .re_i    (accept),
    .raddr_i (vmap.idx),
    .rdata_o (vram_rdata)
  );

  vrp_ram #(
    .WIDTH (8),
    .DEPTH (SPRITE_BYTES)
  ) u_sprite_ram (
    .clk_i   (clk_i),
    .we_i    (spr_we),
    .waddr_i (spr_waddr),
    .wdata_i (spr_wdata),
    .re_i    (accept),
    .raddr_i (oam_addr_q[SprAw-1:0]),
    .rdata_o (spr_rdata)
  );

  // Sequencer: sweep, wait for a beat, finish it
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_cnt_q == VramAw'(vrp_pkg::VRAM_DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_cnt_q <= '0;
    end else begin
      state_q <= state_d;
      if (clearing) begin
        clr_cnt_q <= clr_cnt_q + VramAw'(1);
      end
    end
  end

  // Hold the beat and where it points while memory is read
  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q   <= req_i.action;
      idx_q   <= req_i.reg_index;
      wdata_q <= req_i.write_data;
      vidx_q  <= vmap.idx;
      hit_q   <= vmap.hit;
    end
  end

  // Read state: read-modify-write of the register state
  assign vmem_val = hit_q ? vram_rdata : 8'h00;
  assign step     = ctrl_q[2] ? vrp_pkg::STEP_WIDE : vrp_pkg::STEP_NARROW;

  always_comb begin
    ctrl_d     = ctrl_q;
    mask_d     = mask_q;
    status_d   = status_q;
    oam_addr_d = oam_addr_q;
    toggle_d   = toggle_q;
    vaddr_d    = vaddr_q;
    rbuf_d     = rbuf_q;
    hscroll_d  = hscroll_q;
    vscroll_d  = vscroll_q;
    rd         = 8'h00;
    vram_wr    = 1'b0;
    spr_wr     = 1'b0;
    case (act_q)
      vrp_pkg::ACT_READ: begin
        case (idx_q)
          vrp_pkg::REG_CTRL:     rd = ctrl_q;
          vrp_pkg::REG_MASK:     rd = mask_q;
          vrp_pkg::REG_OAM_ADDR: rd = oam_addr_q;
          vrp_pkg::REG_STATUS: begin
            // Reading status drops the flag bit and resets the toggle
            rd       = status_q;
            status_d = status_q & vrp_pkg::STATUS_KEEP;
            toggle_d = 1'b0;
          end
          vrp_pkg::REG_OAM_DATA: rd = spr_rdata;
          vrp_pkg::REG_DATA: begin
            if (vaddr_q < vrp_pkg::BUS_PAL_LO) begin
              // Buffered read: return the old buffer, refill, advance
              rd      = rbuf_q;
              rbuf_d  = vmem_val;
              vaddr_d = vaddr_q + step;
            end else begin
              rd = vmem_val;
            end
          end
          default: rd = 8'h00;
        endcase
      end
      vrp_pkg::ACT_WRITE: begin
        case (idx_q)
          vrp_pkg::REG_CTRL:     ctrl_d     = wdata_q;
          vrp_pkg::REG_MASK:     mask_d     = wdata_q;
          vrp_pkg::REG_OAM_ADDR: oam_addr_d = wdata_q;
          vrp_pkg::REG_OAM_DATA: spr_wr     = 1'b1;
          vrp_pkg::REG_SCROLL: begin
            if (toggle_q) begin
              vscroll_d = wdata_q;
            end else begin
              hscroll_d = wdata_q;
            end
            toggle_d = !toggle_q;
          end
          vrp_pkg::REG_ADDR: begin
            if (toggle_q) begin
              vaddr_d = {vaddr_q[15:8], wdata_q};
            end else begin
              vaddr_d = {wdata_q, vaddr_q[7:0]};
            end
            toggle_d = !toggle_q;
          end
          vrp_pkg::REG_DATA: begin
            vram_wr = hit_q;
            vaddr_d = vaddr_q + step;
          end
          default: begin
            // Status is read-only from the bus: drop the write
          end
        endcase
      end
      vrp_pkg::ACT_STATUS: status_d = wdata_q;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q     <= '0;
      mask_q     <= '0;
      status_q   <= '0;
      oam_addr_q <= '0;
      toggle_q   <= 1'b0;
      vaddr_q    <= '0;
      rbuf_q     <= '0;
      hscroll_q  <= '0;
      vscroll_q  <= '0;
    end else if (finish) begin
      ctrl_q     <= ctrl_d;
      mask_q     <= mask_d;
      status_q   <= status_d;
      oam_addr_q <= oam_addr_d;
      toggle_q   <= toggle_d;
      vaddr_q    <= vaddr_d;
      rbuf_q     <= rbuf_d;
      hscroll_q  <= hscroll_d;
      vscroll_q  <= vscroll_d;
    end
  end

  // Response register: load on finish, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (finish) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      out_rd_q  <= rd;
      out_hs_q  <= hscroll_d;
      out_vs_q  <= vscroll_d;
      out_ptr_q <= vaddr_d;
    end
  end

  assign rsp_o.valid             = out_valid_q;
  assign rsp_o.read_data         = out_rd_q;
  assign rsp_o.horizontal_scroll = out_hs_q;
  assign rsp_o.vertical_scroll   = out_vs_q;
  assign rsp_o.vram_pointer      = out_ptr_q;

`ifndef ASSERT_OFF
  a_accept_to_read : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_READ))
    else $error("accepted beat did not move to the read cycle");

  a_rsp_from_read : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_READ))
    else $error("response raised outside the read cycle");

  a_vram_write_mapped : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vram_we && !clearing) |-> (hit_q && finish))
    else $error("video memory written at an unmapped address");

  a_no_accept_in_sweep : assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> !accept && !out_valid_q)
    else $error("traffic during the clearing sweep");
`endif

endmodule

@@ tb/vrp_access_checker.sv @@
`timescale 1ns / 1ps

module vrp_access_checker
  import vrp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  vrp_req_if        req_i,
  vrp_rsp_if        rsp_i,
  output int        fail_count_o,
  output int        pending_o
);

  typedef struct packed {
    logic [7:0]  read_data;
    logic [7:0]  horizontal_scroll;
    logic [7:0]  vertical_scroll;
    logic [15:0] vram_pointer;
  } access_rsp_t;

  // Shadow of the port state and of the memories behind it
  logic [7:0]  reg_file [8];
  logic        second_write;
  logic [15:0] vaddr;
  logic [7:0]  data_latch;
  logic [7:0]  hscroll;
  logic [7:0]  vscroll;
  logic [7:0]  oam_mem     [SPRITE_BYTES];
  logic [7:0]  pattern_mem [PATTERN_BYTES];
  logic [7:0]  name_mem    [NT_SPAN];
  logic [7:0]  palette_mem [PALETTE_BYTES];

  access_rsp_t expected_q [$];

  function automatic logic [7:0] vmem_fetch(input logic [15:0] a);
    if (a < BUS_NT_LO) return pattern_mem[a[12:0]];
    if (a < BUS_NT_HI) return name_mem[a[11:0]];
    if (a >= BUS_PAL_LO && a < BUS_PAL_HI) return palette_mem[a[4:0]];
    return 8'h00;
  endfunction

  task automatic vmem_store(input logic [15:0] a, input logic [7:0] v);
    if (a < BUS_NT_LO) pattern_mem[a[12:0]] = v;
    else if (a < BUS_NT_HI) name_mem[a[11:0]] = v;
    else if (a >= BUS_PAL_LO && a < BUS_PAL_HI) palette_mem[a[4:0]] = v;
  endtask

  task automatic step_pointer();
    vaddr = vaddr + (reg_file[REG_CTRL][2] ? STEP_WIDE : STEP_NARROW);
  endtask

  // Apply one access to the shadow state and work out its response
  task automatic predict_access(input logic [1:0] act, input logic [2:0] idx,
                                input logic [7:0] wd, output access_rsp_t exp);
    logic [7:0] rd;
    rd = 8'h00;
    case (act)
      ACT_READ: begin
        case (idx)
          REG_STATUS: begin
            rd = reg_file[REG_STATUS];
            reg_file[REG_STATUS] = reg_file[REG_STATUS] & STATUS_KEEP;
            second_write = 1'b0;
          end
          REG_OAM_DATA: rd = oam_mem[reg_file[REG_OAM_ADDR]];
          REG_DATA: begin
            if (vaddr < BUS_PAL_LO) begin
              rd = data_latch;
              data_latch = vmem_fetch(vaddr);
              step_pointer();
            end else begin
              rd = vmem_fetch(vaddr);
            end
          end
          default: rd = reg_file[idx];
        endcase
      end
      ACT_WRITE: begin
        case (idx)
          REG_CTRL, REG_MASK, REG_OAM_ADDR: reg_file[idx] = wd;
          REG_OAM_DATA: oam_mem[reg_file[REG_OAM_ADDR]] = wd;
          REG_SCROLL: begin
            if (second_write) vscroll = wd;
            else hscroll = wd;
            second_write = ~second_write;
          end
          REG_ADDR: begin
            if (second_write) vaddr = {vaddr[15:8], wd};
            else vaddr = {wd, vaddr[7:0]};
            second_write = ~second_write;
          end
          REG_DATA: begin
            vmem_store(vaddr, wd);
            step_pointer();
          end
          default: ;
        endcase
      end
      ACT_STATUS: reg_file[REG_STATUS] = wd;
      default: ;
    endcase
    exp.read_data         = rd;
    exp.horizontal_scroll = hscroll;
    exp.vertical_scroll   = vscroll;
    exp.vram_pointer      = vaddr;
  endtask

  function automatic bit field_ok(input string name, input logic [15:0] want,
                                  input logic [15:0] got);
    if (want === got) return 1'b1;
    $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    return 1'b0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    access_rsp_t want;
    access_rsp_t got;
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) reg_file[i] = 8'h00;
      for (int i = 0; i < SPRITE_BYTES; i++) oam_mem[i] = 8'h00;
      for (int i = 0; i < PATTERN_BYTES; i++) pattern_mem[i] = 8'h00;
      for (int i = 0; i < NT_SPAN; i++) name_mem[i] = 8'h00;
      for (int i = 0; i < PALETTE_BYTES; i++) palette_mem[i] = 8'h00;
      second_write = 1'b0;
      vaddr        = 16'h0000;
      data_latch   = 8'h00;
      hscroll      = 8'h00;
      vscroll      = 8'h00;
      expected_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (rsp_i.valid && rsp_i.ready) begin
        got.read_data         = rsp_i.read_data;
        got.horizontal_scroll = rsp_i.horizontal_scroll;
        got.vertical_scroll   = rsp_i.vertical_scroll;
        got.vram_pointer      = rsp_i.vram_pointer;
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected response beat, expected none, actual %h", $time, got);
          fail_count_o++;
        end else begin
          want = expected_q.pop_front();
          if (!field_ok("read_data", 16'(want.read_data), 16'(got.read_data)))
            fail_count_o++;
          if (!field_ok("horizontal_scroll", 16'(want.horizontal_scroll),
                        16'(got.horizontal_scroll)))
            fail_count_o++;
          if (!field_ok("vertical_scroll", 16'(want.vertical_scroll),
                        16'(got.vertical_scroll)))
            fail_count_o++;
          if (!field_ok("vram_pointer", want.vram_pointer, got.vram_pointer))
            fail_count_o++;
        end
      end
      if (req_i.valid && req_i.ready) begin
        predict_access(req_i.action, req_i.reg_index, req_i.write_data, want);
        expected_q.push_back(want);
      end
      pending_o = expected_q.size();
    end
  end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import vrp_pkg::*;

  // Directed items plus the random part
  localparam int TOTAL_ITEMS = 575;

  logic clk_i;
  logic rst_ni;
  int   fail_count;
  int   pending;
  int   sent;
  int   req_calm;
  int   rsp_calm;

  vrp_req_if req_if ();
  vrp_rsp_if rsp_if ();

  video_register_port_with_vram i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  vrp_access_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_if),
    .rsp_i        (rsp_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // Draw a random wait; now and then start a calm stretch of back-to-back beats
  function automatic int draw_wait(inout int calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) begin
      calm_left = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 17);
  endfunction

  // Offer one request beat: hold off for the drawn gap, then hold valid until it is taken.
  // Valid stays high across back-to-back beats, only the payload moves.
  task automatic send(input logic [1:0] act, input logic [2:0] idx, input logic [7:0] wd);
    int gap;
    gap = draw_wait(req_calm);
    if (gap > 0) begin
      req_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_if.valid      = 1'b1;
    req_if.action     = act;
    req_if.reg_index  = idx;
    req_if.write_data = wd;
    do @(posedge clk_i); while (!req_if.ready);
    @(negedge clk_i);
    sent++;
  endtask

  // Two writes to the address register: high byte first, assuming the toggle is clear
  task automatic set_pointer(input logic [15:0] addr);
    send(ACT_WRITE, REG_ADDR, addr[15:8]);
    send(ACT_WRITE, REG_ADDR, addr[7:0]);
  endtask

  // Pick a pointer in one of the video memory regions, edges and wrap included
  function automatic logic [15:0] pick_pointer();
    case ($urandom_range(0, 7))
      0: return 16'($urandom_range(16'h0000, 16'h1FFF));
      1: return 16'($urandom_range(16'h0000, 16'h003F));   // small window, many revisits
      2: return 16'($urandom_range(16'h2000, 16'h2FFF));
      3: return 16'($urandom_range(16'h2FF0, 16'h300F));   // name tables into the hole
      4: return 16'($urandom_range(16'h3000, 16'h3EFF));
      5: return 16'($urandom_range(16'h3EF0, 16'h3F2F));   // around the palette
      6: return 16'($urandom_range(16'h3F20, 16'hFFFF));
      default: return 16'($urandom_range(16'hFFE0, 16'hFFFF));
    endcase
  endfunction

  // Response side: stall a drawn number of cycles before each beat, then hold ready until taken
  initial begin
    int stall;
    rsp_if.ready = 1'b0;
    rsp_calm     = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      stall = draw_wait(rsp_calm);
      if (stall > 0) begin
        rsp_if.ready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      rsp_if.ready = 1'b1;
      do @(posedge clk_i); while (!rsp_if.valid);
    end
  end

  // Watchdog: far beyond the slowest correct run, clearing sweep included
  initial begin
    #1_000_000;
    $display("tb failed");
    $finish;
  end

  initial begin
    logic [15:0] base;
    int          len;
    int          kind;
    req_if.valid      = 1'b0;
    req_if.action     = ACT_READ;
    req_if.reg_index  = REG_CTRL;
    req_if.write_data = 8'h00;
    rst_ni   = 1'b0;
    sent     = 0;
    req_calm = 0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part: plain registers, sprite RAM, status clear-on-read, scroll pair
    send(ACT_WRITE, REG_MASK, 8'hA5);
    send(ACT_READ, REG_MASK, 8'h00);
    send(ACT_WRITE, REG_OAM_ADDR, 8'hFF);
    send(ACT_WRITE, REG_OAM_DATA, 8'h5A);
    send(ACT_READ, REG_OAM_DATA, 8'hFF);
    // Status is read-only from the bus: the write must leave it alone
    send(ACT_WRITE, REG_STATUS, 8'h12);
    send(ACT_STATUS, REG_CTRL, 8'hC3);
    send(ACT_READ, REG_STATUS, 8'h00);
    send(ACT_READ, REG_STATUS, 8'h00);
    send(ACT_WRITE, REG_SCROLL, 8'hFF);
    send(ACT_WRITE, REG_SCROLL, 8'h00);
    send(ACT_READ, REG_SCROLL, 8'h00);
    send(ACT_READ, REG_ADDR, 8'h00);
    // Palette write, then a direct palette read that must not advance the pointer
    set_pointer(16'h3F00);
    send(ACT_WRITE, REG_DATA, 8'h2A);
    set_pointer(16'h3F00);
    send(ACT_READ, REG_DATA, 8'h00);
    // Buffered read from the hole below the palette still advances
    set_pointer(16'h3EFF);
    send(ACT_READ, REG_DATA, 8'h00);
    // Wide step and wrap of the pointer past the top of the map
    send(ACT_WRITE, REG_CTRL, 8'h04);
    set_pointer(16'hFFF0);
    send(ACT_WRITE, REG_DATA, 8'h77);
    // Unused access kind: nothing changes
    send(2'd3, REG_DATA, 8'hFF);

    // Random part: mostly write bursts read back through the buffer
    while (sent < TOTAL_ITEMS) begin
      kind = $urandom_range(0, 9);
      if (kind <= 5) begin
        base = pick_pointer();
        len  = $urandom_range(1, 6);
        // Clear the toggle first most of the time; otherwise the address pair may land swapped
        if ($urandom_range(0, 4) != 0) send(ACT_READ, REG_STATUS, 8'($urandom));
        set_pointer(base);
        for (int i = 0; i < len; i++) send(ACT_WRITE, REG_DATA, 8'($urandom));
        if ($urandom_range(0, 4) != 0) send(ACT_READ, REG_STATUS, 8'($urandom));
        set_pointer(base);
        for (int i = 0; i <= len; i++) send(ACT_READ, REG_DATA, 8'($urandom));
      end else if (kind == 6) begin
        send(ACT_WRITE, REG_CTRL, 8'($urandom));
        send(ACT_READ, REG_CTRL, 8'($urandom));
        send(ACT_WRITE, REG_MASK, 8'($urandom));
      end else if (kind == 7) begin
        send(ACT_WRITE, REG_OAM_ADDR, 8'($urandom));
        repeat ($urandom_range(1, 3)) send(ACT_WRITE, REG_OAM_DATA, 8'($urandom));
        send(ACT_READ, REG_OAM_DATA, 8'($urandom));
        send(ACT_READ, REG_OAM_ADDR, 8'($urandom));
      end else if (kind == 8) begin
        send(ACT_STATUS, 3'($urandom), 8'($urandom));
        send(ACT_READ, REG_STATUS, 8'($urandom));
        send(ACT_WRITE, REG_SCROLL, 8'($urandom));
        send(ACT_WRITE, REG_SCROLL, 8'($urandom));
        send(ACT_READ, 3'($urandom_range(0, 6)), 8'($urandom));
      end else begin
        // Noise: any access kind, any register, any byte
        repeat ($urandom_range(1, 6)) send(2'($urandom), 3'($urandom), 8'($urandom));
      end
    end
    req_if.valid = 1'b0;

    // Drain: wait for every response, then a short tail to catch stray beats
    wait (pending == 0);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
